// ===== design/dual_countdown_game_clock_assert.svh =====
// Assertion macros for the dual countdown game clock.
`ifndef DUAL_COUNTDOWN_GAME_CLOCK_ASSERT_SVH
`define DUAL_COUNTDOWN_GAME_CLOCK_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DCGC_CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dcgc check failed");

// Next-cycle implication, checked out of reset.
`define DCGC_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dcgc check failed");

`endif

// ===== design/dcgc_pkg.sv =====
// Shared types and constants of the dual countdown game clock.
package dcgc_pkg;

    typedef enum logic [2:0] {
        KIND_TICK   = 3'd0,
        KIND_PAUSE  = 3'd1,
        KIND_FLIP   = 3'd2,
        KIND_TOP    = 3'd3,
        KIND_BOTTOM = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        MODE_WHITE  = 2'd0,
        MODE_BLACK  = 2'd1,
        MODE_PAUSED = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        STAT_NORMAL = 2'd0,
        STAT_WARN   = 2'd1,
        STAT_FLAG   = 2'd2
    } t_status;

    // stage load strobes
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_pipe_ctl;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WARN       = 1'b1;

    localparam logic [15:0] DEFAULT_START = 16'd1800;
    localparam logic [15:0] DEFAULT_WARN  = 16'd60;

    localparam int SECS_PER_MIN = 60;
    localparam int SECS_PER_HR  = 3600;

endpackage

// ===== design/dcgc_state.sv =====
// Clock state update and the per-beat snapshot register.
module dcgc_state #(
    parameter int TIME_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dcgc_pkg::t_pipe_ctl               i_ctl,
    input  logic [2:0]                        i_kind,
    input  logic [7:0]                        i_elapsed,
    input  logic                              i_cfg_we,
    input  logic [dcgc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dcgc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output logic [TIME_BITS-1:0]              o_white,
    output logic [TIME_BITS-1:0]              o_black,
    output dcgc_pkg::t_mode                   o_mode,
    output logic                              o_orient,
    output logic                              o_click,
    output logic [15:0]                       o_threshold
);
    import dcgc_pkg::*;

    localparam logic [31:0] START_EXT = 32'(DEFAULT_START);
    localparam logic [TIME_BITS-1:0] RESET_COUNT = START_EXT[TIME_BITS-1:0];

    logic [TIME_BITS-1:0] r_white, n_white;
    logic [TIME_BITS-1:0] r_black, n_black;
    t_mode                r_mode, n_mode;
    t_mode                r_prev, n_prev;
    logic                 r_orient, n_orient;
    logic [15:0]          r_thr;
    logic                 n_click;

    logic [TIME_BITS-1:0] r_s1_white;
    logic [TIME_BITS-1:0] r_s1_black;
    t_mode                r_s1_mode;
    logic                 r_s1_orient;
    logic                 r_s1_click;

    logic [TIME_BITS:0]   w_diff_w;
    logic [TIME_BITS:0]   w_diff_b;
    logic [31:0]          w_wdata_ext;
    t_mode                w_target;

    assign w_diff_w    = {1'b0, r_white} - (TIME_BITS+1)'(i_elapsed);
    assign w_diff_b    = {1'b0, r_black} - (TIME_BITS+1)'(i_elapsed);
    assign w_wdata_ext = 32'(i_cfg_wdata);

    always_comb begin
        n_white  = r_white;
        n_black  = r_black;
        n_mode   = r_mode;
        n_prev   = r_prev;
        n_orient = r_orient;
        n_click  = 1'b0;
        w_target = MODE_PAUSED;
        case (i_kind)
            KIND_TICK: begin
                // borrow out means elapsed exceeded the count: stop at zero
                if (r_mode == MODE_WHITE) begin
                    n_white = w_diff_w[TIME_BITS] ? '0 : w_diff_w[TIME_BITS-1:0];
                end else if (r_mode == MODE_BLACK) begin
                    n_black = w_diff_b[TIME_BITS] ? '0 : w_diff_b[TIME_BITS-1:0];
                end
            end
            KIND_PAUSE: begin
                n_mode = (r_mode != MODE_PAUSED) ? MODE_PAUSED : r_prev;
                n_prev = r_mode;
            end
            KIND_FLIP: begin
                n_orient = ~r_orient;
            end
            KIND_TOP, KIND_BOTTOM: begin
                // a press starts the player who does not own the button
                if ((i_kind == KIND_TOP) == r_orient) begin
                    w_target = MODE_WHITE;
                end else begin
                    w_target = MODE_BLACK;
                end
                n_click = (r_mode != w_target);
                n_prev  = r_mode;
                n_mode  = w_target;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white  <= RESET_COUNT;
            r_black  <= RESET_COUNT;
            r_mode   <= MODE_PAUSED;
            r_prev   <= MODE_PAUSED;
            r_orient <= 1'b1;
            r_thr    <= DEFAULT_WARN;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_START_TIME) begin
                r_white <= w_wdata_ext[TIME_BITS-1:0];
                r_black <= w_wdata_ext[TIME_BITS-1:0];
            end else if (i_cfg_idx == REG_WARN) begin
                r_thr <= i_cfg_wdata;
            end
        end else if (i_ctl.ld1) begin
            r_white  <= n_white;
            r_black  <= n_black;
            r_mode   <= n_mode;
            r_prev   <= n_prev;
            r_orient <= n_orient;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_s1_white  <= n_white;
            r_s1_black  <= n_black;
            r_s1_mode   <= n_mode;
            r_s1_orient <= n_orient;
            r_s1_click  <= n_click;
        end
    end

    assign o_white     = r_s1_white;
    assign o_black     = r_s1_black;
    assign o_mode      = r_s1_mode;
    assign o_orient    = r_s1_orient;
    assign o_click     = r_s1_click;
    assign o_threshold = r_thr;

endmodule

// ===== design/dcgc_split.sv =====
// Minutes, seconds and status of one side, two register stages.
module dcgc_split #(
    parameter int TIME_BITS = 16
) (
    input  logic                  i_clk,
    input  dcgc_pkg::t_pipe_ctl   i_ctl,
    input  logic [TIME_BITS-1:0]  i_count,
    input  logic [15:0]           i_threshold,
    output logic [15:0]           o_time,
    output logic [5:0]            o_minutes,
    output logic [5:0]            o_seconds,
    output dcgc_pkg::t_status     o_status
);
    import dcgc_pkg::*;

    localparam int PW    = 2*TIME_BITS + 1;
    localparam int K_MIN = TIME_BITS + 6;
    localparam int K_HR  = TIME_BITS + 12;
    // ceil(2^k / d): exact quotient for any TIME_BITS-wide count
    localparam logic [63:0] M_MIN =
        ((64'd1 << K_MIN) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN);
    localparam logic [63:0] M_HR =
        ((64'd1 << K_HR) + 64'(SECS_PER_HR) - 64'd1) / 64'(SECS_PER_HR);
    localparam logic [TIME_BITS-1:0] C60 = TIME_BITS'(SECS_PER_MIN);

    logic [PW-1:0]        w_p_min;
    logic [PW-1:0]        w_p_hr;
    t_status              w_status;

    logic [TIME_BITS-1:0] r_cnt;
    logic [TIME_BITS-1:0] r_q;
    logic [TIME_BITS-1:0] r_h;
    t_status              r_stat;

    logic [31:0]          w_cnt_ext;
    logic [TIME_BITS-1:0] w_sec;
    logic [TIME_BITS-1:0] w_min;

    logic [15:0]          r_time;
    logic [5:0]           r_min;
    logic [5:0]           r_sec;
    t_status              r_stat_o;

    assign w_p_min = PW'(i_count) * PW'(M_MIN[TIME_BITS:0]);
    assign w_p_hr  = PW'(i_count) * PW'(M_HR[TIME_BITS:0]);

    always_comb begin
        if (i_count == '0) begin
            w_status = STAT_FLAG;
        end else if (32'(i_count) < 32'(i_threshold)) begin
            w_status = STAT_WARN;
        end else begin
            w_status = STAT_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_cnt  <= i_count;
            r_q    <= TIME_BITS'(w_p_min >> K_MIN);
            r_h    <= TIME_BITS'(w_p_hr >> K_HR);
            r_stat <= w_status;
        end
    end

    // remainders by constant multiply and subtract; both are below 60
    assign w_cnt_ext = 32'(r_cnt);
    assign w_sec     = r_cnt - r_q * C60;
    assign w_min     = r_q - r_h * C60;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_time   <= w_cnt_ext[15:0];
            r_min    <= w_min[5:0];
            r_sec    <= w_sec[5:0];
            r_stat_o <= r_stat;
        end
    end

    assign o_time    = r_time;
    assign o_minutes = r_min;
    assign o_seconds = r_sec;
    assign o_status  = r_stat_o;

endmodule

// ===== design/dual_countdown_game_clock.sv =====
// Top level of the dual countdown game clock: handshake pipeline and result packing.
//
//  channel | dir | width             | content
//  --------+-----+-------------------+----------------------------------------
//  s_      | in  | tdata 8, tuser 3  | one event beat: kind, elapsed seconds
//  m_      | out | tdata 64          | one result beat per event beat
//  i_cfg_  | in  | idx 1, wdata 16   | register writes: start time, threshold
//
//  One beat per cycle sustained while m_tready stays high; each beat passes
//  the state update, reciprocal multiply and remainder stages in turn.
//  Each stage loads when empty or when the stage after it moves, so input
//  can still be taken while a finished result waits on m_tready.
//  Reset is synchronous, active low, and needs no clearing pass.
`include "dual_countdown_game_clock_assert.svh"
module dual_countdown_game_clock #(
    parameter int TIME_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,    // [7:0] elapsed
    input  logic [2:0]                        s_tuser,    // [2:0] kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] white_time, [31:16] black_time, [37:32] white_minutes,
    // [43:38] white_seconds, [49:44] black_minutes, [55:50] black_seconds,
    // [57:56] white_status, [59:58] black_status, [61:60] running_side,
    // [62] white_on_bottom, [63] click
    output logic [63:0]                       m_tdata,
    input  logic                              i_cfg_we,
    input  logic [dcgc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dcgc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import dcgc_pkg::*;

    t_pipe_ctl            w_ctl;
    logic                 r_v1, r_v2, r_v3;
    logic                 w_rdy1, w_rdy2, w_rdy3;

    logic [TIME_BITS-1:0] w_s1_white;
    logic [TIME_BITS-1:0] w_s1_black;
    t_mode                w_s1_mode;
    logic                 w_s1_orient;
    logic                 w_s1_click;
    logic [15:0]          w_thr;

    t_mode                r_s2_mode, r_s3_mode;
    logic                 r_s2_orient, r_s3_orient;
    logic                 r_s2_click, r_s3_click;

    logic [15:0]          w_w_time, w_b_time;
    logic [5:0]           w_w_min, w_w_sec, w_b_min, w_b_sec;
    t_status              w_w_stat, w_b_stat;

    assign w_rdy3    = !r_v3 || m_tready;
    assign w_rdy2    = !r_v2 || w_rdy3;
    assign w_rdy1    = !r_v1 || w_rdy2;
    assign w_ctl.ld3 = r_v2 && w_rdy3;
    assign w_ctl.ld2 = r_v1 && w_rdy2;
    assign w_ctl.ld1 = s_tvalid && w_rdy1;
    assign s_tready  = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ctl.ld1) begin
                r_v1 <= 1'b1;
            end else if (w_ctl.ld2) begin
                r_v1 <= 1'b0;
            end
            if (w_ctl.ld2) begin
                r_v2 <= 1'b1;
            end else if (w_ctl.ld3) begin
                r_v2 <= 1'b0;
            end
            if (w_ctl.ld3) begin
                r_v3 <= 1'b1;
            end else if (m_tready) begin
                r_v3 <= 1'b0;
            end
        end
    end

    dcgc_state #(
        .TIME_BITS (TIME_BITS)
    ) u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_kind      (s_tuser),
        .i_elapsed   (s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_white     (w_s1_white),
        .o_black     (w_s1_black),
        .o_mode      (w_s1_mode),
        .o_orient    (w_s1_orient),
        .o_click     (w_s1_click),
        .o_threshold (w_thr)
    );

    dcgc_split #(
        .TIME_BITS (TIME_BITS)
    ) u_split_white (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_count     (w_s1_white),
        .i_threshold (w_thr),
        .o_time      (w_w_time),
        .o_minutes   (w_w_min),
        .o_seconds   (w_w_sec),
        .o_status    (w_w_stat)
    );

    dcgc_split #(
        .TIME_BITS (TIME_BITS)
    ) u_split_black (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_count     (w_s1_black),
        .i_threshold (w_thr),
        .o_time      (w_b_time),
        .o_minutes   (w_b_min),
        .o_seconds   (w_b_sec),
        .o_status    (w_b_stat)
    );

    always_ff @(posedge i_clk) begin
        if (w_ctl.ld2) begin
            r_s2_mode   <= w_s1_mode;
            r_s2_orient <= w_s1_orient;
            r_s2_click  <= w_s1_click;
        end
        if (w_ctl.ld3) begin
            r_s3_mode   <= r_s2_mode;
            r_s3_orient <= r_s2_orient;
            r_s3_click  <= r_s2_click;
        end
    end

    assign m_tvalid = r_v3;
    assign m_tdata  = {r_s3_click, r_s3_orient, r_s3_mode, w_b_stat, w_w_stat,
                       w_b_sec, w_b_min, w_w_sec, w_w_min, w_b_time, w_w_time};

    `DCGC_CHK_NEXT(a_accept_fills, s_tvalid && s_tready, r_v1)
    `DCGC_CHK_NOW(a_click_running, m_tvalid && m_tdata[63], m_tdata[61:60] != MODE_PAUSED)
    `DCGC_CHK_NOW(a_white_range, m_tvalid, (m_tdata[37:32] < 6'd60) && (m_tdata[43:38] < 6'd60))
    `DCGC_CHK_NOW(a_black_range, m_tvalid, (m_tdata[49:44] < 6'd60) && (m_tdata[55:50] < 6'd60))

endmodule
